// ===== rtl/core/ssst_pkg.sv =====
// ----------------------------------------------------------------------------
// ssst_pkg: shared types and constants for the sorted site set table
// Table size, key width, request/result payloads and cell control.
// ----------------------------------------------------------------------------
package ssst_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int KEY_WIDTH   = 32;
  localparam int POS_W       = 32;
  localparam int OCC_W       = 9;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int GRP_SIZE    = 16;
  localparam int GRP_NUM     = (TABLE_DEPTH + GRP_SIZE - 1) / GRP_SIZE;

  localparam logic CMD_LOOKUP   = 1'b0;
  localparam logic CMD_WRITE    = 1'b1;
  localparam logic MARK_REMOVE  = 1'b0;
  localparam logic MARK_INSERT  = 1'b1;
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_FULL  = 1'b1;

  typedef logic [KEY_WIDTH-1:0] key_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  typedef struct packed {
    logic             command;
    logic [POS_W-1:0] position;
    logic             mark;
  } ssst_in_t;

  typedef struct packed {
    logic             present;
    logic             status;
    logic [OCC_W-1:0] occupancy;
  } ssst_out_t;

  typedef struct packed {
    logic cmp;
    logic ins;
    logic del;
    key_t key;
  } ssst_cell_ctl_t;

endpackage

// ===== rtl/core/ssst_cell.sv =====
// ----------------------------------------------------------------------------
// ssst_cell: one slot of the sorted key chain
// Holds one key and its valid bit, compares against the broadcast key and
// shifts toward either neighbor on insert or remove.
// ----------------------------------------------------------------------------
module ssst_cell
  import ssst_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  ssst_cell_ctl_t ctl,
  input  key_t           left_key,
  input  logic           left_valid,
  input  logic           left_lt,
  input  key_t           right_key,
  input  logic           right_valid,
  output key_t           key,
  output logic           valid,
  output logic           lt,
  output logic           eq
);

  key_t key_r, key_nxt;
  logic valid_r, valid_nxt;
  logic lt_r, lt_nxt;
  logic eq_r, eq_nxt;
  logic here, shift_in, shift_out;

  always_comb begin
    here      = left_lt && !lt_r;
    shift_in  = left_valid && !left_lt;
    shift_out = valid_r && !lt_r;
    key_nxt   = key_r;
    valid_nxt = valid_r;
    lt_nxt    = lt_r;
    eq_nxt    = eq_r;
    if (ctl.cmp) begin
      lt_nxt = valid_r && (key_r < ctl.key);
      eq_nxt = valid_r && (key_r == ctl.key);
    end
    if (ctl.ins) begin
      if (here) begin
        key_nxt   = ctl.key;
        valid_nxt = 1'b1;
      end else if (shift_in) begin
        key_nxt   = left_key;
        valid_nxt = left_valid;
      end
    end else if (ctl.del) begin
      if (shift_out) begin
        key_nxt   = right_key;
        valid_nxt = right_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      lt_r    <= 1'b0;
      eq_r    <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      lt_r    <= lt_nxt;
      eq_r    <= eq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign key   = key_r;
  assign valid = valid_r;
  assign lt    = lt_r;
  assign eq    = eq_r;

endmodule

// ===== rtl/core/ssst_hit_tree.sv =====
// ----------------------------------------------------------------------------
// ssst_hit_tree: registered match reduction
// Folds the per-cell match flags into registered group flags; hit is the
// OR of the group flags.
// ----------------------------------------------------------------------------
module ssst_hit_tree
  import ssst_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [TABLE_DEPTH-1:0] eq_vec,
  output logic                   hit
);

  localparam int PAD_W = GRP_NUM * GRP_SIZE;

  logic [PAD_W-1:0]   eq_pad;
  logic [GRP_NUM-1:0] grp_r, grp_nxt;

  assign eq_pad = PAD_W'(eq_vec);

  for (genvar g = 0; g < GRP_NUM; g++) begin : g_grp
    assign grp_nxt[g] = |eq_pad[g*GRP_SIZE +: GRP_SIZE];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_r <= '0;
    end else begin
      grp_r <= grp_nxt;
    end
  end

  assign hit = |grp_r;

endmodule

// ===== rtl/core/sorted_site_set_table_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_site_set_table_unit: sorted set of marked site positions
// Lookup, insert and remove of positions held in ascending order in a
// chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
//  channel | ports                          | payload
//  --------+--------------------------------+-----------------------------
//  request | in_valid / in_ready / in_data  | command, position, mark
//  result  | out_valid / out_ready/out_data | present, status, occupancy
//
//  Each request passes through accept, cell compare, match reduction, apply.
//  The apply step waits while an earlier result is still held at the output.
//  One request is in the chain at a time; in_ready is high only when idle.
//  Reset clears all valid bits and the count.
// ----------------------------------------------------------------------------
module sorted_site_set_table_unit
  import ssst_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  ssst_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output ssst_out_t out_data
);

  typedef enum logic [1:0] {S_IDLE, S_CMP, S_RED, S_APPLY} state_t;

  state_t         state_r;
  ssst_in_t       req_r;
  cnt_t           cnt_r, cnt_nxt;
  logic           out_valid_r;
  ssst_out_t      out_r, res_nxt;
  ssst_cell_ctl_t ctl;
  key_t           req_key;
  logic           hit, full, go, is_write, do_ins, do_del;

  key_t                   cell_key [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] cell_valid, cell_lt, cell_eq;

  assign req_key  = KEY_WIDTH'(req_r.position);
  assign full     = (cnt_r == cnt_t'(TABLE_DEPTH));
  assign go       = (state_r == S_APPLY) && (!out_valid_r || out_ready);
  assign is_write = (req_r.command == CMD_WRITE);
  assign do_ins   = go && is_write && (req_r.mark == MARK_INSERT) && !hit && !full;
  assign do_del   = go && is_write && (req_r.mark == MARK_REMOVE) && hit;

  always_comb begin
    ctl.cmp = (state_r == S_CMP);
    ctl.ins = do_ins;
    ctl.del = do_del;
    ctl.key = req_key;
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_ins) begin
      cnt_nxt = cnt_r + cnt_t'(1);
    end else if (do_del) begin
      cnt_nxt = cnt_r - cnt_t'(1);
    end
    res_nxt.status  = STATUS_OK;
    res_nxt.present = 1'b0;
    if (!is_write) begin
      res_nxt.present = hit;
    end else if (req_r.mark == MARK_INSERT) begin
      if (hit || !full) begin
        res_nxt.present = 1'b1;
      end else begin
        res_nxt.status = STATUS_FULL;
      end
    end
    res_nxt.occupancy = OCC_W'(cnt_nxt);
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    key_t lkey, rkey;
    logic lval, llt, rval;
    if (i == 0) begin : g_first
      assign lkey = '0;
      assign lval = 1'b0;
      assign llt  = 1'b1;
    end else begin : g_mid
      assign lkey = cell_key[i-1];
      assign lval = cell_valid[i-1];
      assign llt  = cell_lt[i-1];
    end
    if (i == TABLE_DEPTH - 1) begin : g_last
      assign rkey = '0;
      assign rval = 1'b0;
    end else begin : g_body
      assign rkey = cell_key[i+1];
      assign rval = cell_valid[i+1];
    end
    ssst_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .left_key    (lkey),
      .left_valid  (lval),
      .left_lt     (llt),
      .right_key   (rkey),
      .right_valid (rval),
      .key         (cell_key[i]),
      .valid       (cell_valid[i]),
      .lt          (cell_lt[i]),
      .eq          (cell_eq[i])
    );
  end

  ssst_hit_tree u_hit_tree (
    .clk    (clk),
    .rst_n  (rst_n),
    .eq_vec (cell_eq),
    .hit    (hit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (go) begin
        out_valid_r <= 1'b1;
        out_r       <= res_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            req_r   <= in_data;
            state_r <= S_CMP;
          end
        end
        S_CMP:   state_r <= S_RED;
        S_RED:   state_r <= S_APPLY;
        S_APPLY: begin
          if (go) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= cnt_t'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_valid_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cell_valid) == int'(cnt_r))
    else $error("valid bits disagree with entry count");

  a_full_absent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_r.status == STATUS_FULL) |-> !out_r.present)
    else $error("dropped insert reported present");

  a_ins_del_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(do_ins && do_del))
    else $error("insert and remove in the same cycle");

  a_apply_result: assert property (@(posedge clk) disable iff (!rst_n)
    go |=> out_valid_r && (state_r == S_IDLE))
    else $error("apply step left no result");

endmodule
